[hw/rtl/jqd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// jqd_pkg
// Shared types, codes and sizes for the multi-class job queue dispatcher.
// ----------------------------------------------------------------------------
package jqd_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int NUM_QUEUES  = 5;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int QSEL_W      = $clog2(NUM_QUEUES);

    localparam int ID_W     = 16;
    localparam int TIME_W   = 24;
    localparam int CPU_W    = 16;
    localparam int GPU_W    = 12;
    localparam int NODES_W  = 12;
    localparam int FACTOR_W = 8;
    localparam int CLASS_W  = 3;
    localparam int STATUS_W = 3;
    localparam int PROD_W   = NODES_W + FACTOR_W;
    localparam int CFG_IDX_W = 1;

    localparam logic [FACTOR_W-1:0] CPU_FACTOR_RESET = 8'd16;
    localparam logic [FACTOR_W-1:0] GPU_FACTOR_RESET = 8'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CPU_FACTOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GPU_FACTOR = 1'd1;

    localparam logic ACT_ADD = 1'b0;
    localparam logic ACT_ASK = 1'b1;

    localparam logic [CLASS_W-1:0] CLS_SHORT  = 3'd0;
    localparam logic [CLASS_W-1:0] CLS_MEDIUM = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_LARGE  = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_HUGE   = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_GPU    = 3'd4;
    localparam logic [CLASS_W-1:0] CLS_MULTI  = 3'd5;

    localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_GRANTED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NONE    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD     = 3'd4;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] run_time;
        logic [CPU_W-1:0]  cpu_need;
        logic [GPU_W-1:0]  gpu_need;
    } job_t;

    typedef struct packed {
        logic push;
        logic pop;
    } q_ctl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage
`default_nettype wire

[hw/rtl/multi_class_job_queue_dispatcher_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// multi_class_job_queue_dispatcher_top
// Five class job FIFOs with add, per-class ask and longest-job multi ask.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one request per handshake. action 0 adds a job to the queue
//   of job_class; action 1 asks for a job of job_class, offering
//   available_nodes. Every request yields exactly one m_* result.
//   cfg_* channel: cfg_index 0 writes the CPU node factor, 1 the GPU node
//   factor; always ready. Write only while the block is idle.
//   Timing: a request accepted into the input register is decided and loaded
//   into the result register once that register is free or being read, so
//   m_valid is high from then on.
//   Throughput: one request per cycle while m_ready drains the result; the
//   queue heads sit in flops, so the decision and the queue update close as the request advances.
//   Stall: while m_ready is low the result holds, the input register holds
//   one more request, then s_ready drops.
//   Reset: all queues empty, factors 16 (CPU) and 2 (GPU), both channels
//   empty.
// ----------------------------------------------------------------------------
module multi_class_job_queue_dispatcher_top
    import jqd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [FACTOR_W-1:0]  cfg_data,

    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_action,
    input  wire logic [CLASS_W-1:0]   s_job_class,
    input  wire logic [ID_W-1:0]      s_job_id,
    input  wire logic [TIME_W-1:0]    s_run_time,
    input  wire logic [CPU_W-1:0]     s_cpu_need,
    input  wire logic [GPU_W-1:0]     s_gpu_need,
    input  wire logic [NODES_W-1:0]   s_available_nodes,

    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [STATUS_W-1:0]       m_status,
    output logic [CLASS_W-1:0]        m_granted_class,
    output logic [ID_W-1:0]           m_granted_id,
    output logic [TIME_W-1:0]         m_granted_time,
    output logic [CPU_W-1:0]          m_granted_cpu_need,
    output logic [GPU_W-1:0]          m_granted_gpu_need
);

    logic [FACTOR_W-1:0] cpu_factor_reg, gpu_factor_reg;

    logic                in_valid_reg;
    logic                in_action_reg;
    logic [CLASS_W-1:0]  in_class_reg;
    job_t                in_job_reg;
    logic [NODES_W-1:0]  in_nodes_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [CLASS_W-1:0]  out_class_reg, out_class_next;
    job_t                out_job_reg, out_job_next;

    logic                advance;
    logic                s_take;

    q_ctl_t              q_ctl  [NUM_QUEUES];
    q_stat_t             q_stat [NUM_QUEUES];
    job_t                q_head [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] push_vec, pop_vec, empty_vec, full_vec;

    logic                multi_found;
    logic [QSEL_W-1:0]   multi_q;
    logic [TIME_W-1:0]   multi_time;
    logic                cand_ok;
    logic [QSEL_W-1:0]   cand_q;
    job_t                cand_job;
    logic [FACTOR_W-1:0] factor_sel;
    logic [PROD_W-1:0]   offer;
    logic [PROD_W-1:0]   need;
    logic                do_grant;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cpu_factor_reg <= CPU_FACTOR_RESET;
            gpu_factor_reg <= GPU_FACTOR_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_CPU_FACTOR: cpu_factor_reg <= cfg_data;
                REG_GPU_FACTOR: gpu_factor_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // handshake
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_take) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_action_reg       <= s_action;
            in_class_reg        <= s_job_class;
            in_job_reg.id       <= s_job_id;
            in_job_reg.run_time <= s_run_time;
            in_job_reg.cpu_need <= s_cpu_need;
            in_job_reg.gpu_need <= s_gpu_need;
            in_nodes_reg        <= s_available_nodes;
        end
        if (advance) begin
            out_status_reg <= out_status_next;
            out_class_reg  <= out_class_next;
            out_job_reg    <= out_job_next;
        end
    end

    // queues
    for (genvar q = 0; q < NUM_QUEUES; q++) begin : g_queue
        assign q_ctl[q].push = push_vec[q];
        assign q_ctl[q].pop  = pop_vec[q];
        assign empty_vec[q]  = q_stat[q].empty;
        assign full_vec[q]   = q_stat[q].full;

        jqd_queue u_queue (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (q_ctl[q]),
            .wr_job   (in_job_reg),
            .head_job (q_head[q]),
            .stat     (q_stat[q])
        );
    end

    // multi: longest head among short, medium, large; earlier class on ties
    always_comb begin
        multi_found = 1'b0;
        multi_q     = QSEL_W'(CLS_SHORT);
        multi_time  = '0;
        for (int q = 0; q < 3; q++) begin
            if (!empty_vec[q] && (!multi_found || q_head[q].run_time > multi_time)) begin
                multi_found = 1'b1;
                multi_q     = QSEL_W'(q);
                multi_time  = q_head[q].run_time;
            end
        end
    end

    // decision
    always_comb begin
        push_vec        = '0;
        pop_vec         = '0;
        cand_ok         = 1'b0;
        cand_q          = QSEL_W'(CLS_SHORT);
        out_status_next = ST_NONE;
        out_class_next  = '0;
        out_job_next    = '0;

        if (in_action_reg == ACT_ASK) begin
            unique case (in_class_reg)
                CLS_SHORT, CLS_MEDIUM, CLS_GPU: begin
                    cand_q  = QSEL_W'(in_class_reg);
                    cand_ok = !empty_vec[QSEL_W'(in_class_reg)];
                end
                CLS_LARGE, CLS_HUGE: begin
                    cand_ok = 1'b0;
                end
                CLS_MULTI: begin
                    cand_q  = multi_q;
                    cand_ok = multi_found;
                end
                default: begin
                    out_status_next = ST_BAD;
                end
            endcase
        end

        cand_job   = q_head[cand_q];
        factor_sel = (in_class_reg == CLS_GPU) ? gpu_factor_reg : cpu_factor_reg;
        offer      = PROD_W'(in_nodes_reg) * PROD_W'(factor_sel);
        need       = (in_class_reg == CLS_GPU) ? PROD_W'(cand_job.gpu_need)
                                               : PROD_W'(cand_job.cpu_need);
        do_grant   = (in_action_reg == ACT_ASK) && cand_ok && (offer >= need);

        if (in_action_reg == ACT_ADD) begin
            if (in_class_reg > CLS_GPU) begin
                out_status_next = ST_BAD;
            end else if (full_vec[QSEL_W'(in_class_reg)]) begin
                out_status_next = ST_FULL;
            end else begin
                out_status_next = ST_ADDED;
                push_vec[QSEL_W'(in_class_reg)] = advance;
            end
        end else if (do_grant) begin
            out_status_next = ST_GRANTED;
            out_class_next  = CLASS_W'(cand_q);
            out_job_next    = cand_job;
            pop_vec[cand_q] = advance;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_status           = out_status_reg;
    assign m_granted_class    = out_class_reg;
    assign m_granted_id       = out_job_reg.id;
    assign m_granted_time     = out_job_reg.run_time;
    assign m_granted_cpu_need = out_job_reg.cpu_need;
    assign m_granted_gpu_need = out_job_reg.gpu_need;

    a_grant_class: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_GRANTED |->
            m_granted_class != CLS_HUGE && m_granted_class != CLS_MULTI &&
            m_granted_class <= CLS_GPU)
        else $error("grant from a class that cannot be granted");

    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_GRANTED |->
            m_granted_class == '0 && m_granted_id == '0 && m_granted_time == '0 &&
            m_granted_cpu_need == '0 && m_granted_gpu_need == '0)
        else $error("granted fields not cleared");

    a_one_queue_op: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({push_vec, pop_vec}))
        else $error("more than one queue operation per request");

    a_stall_only: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled without output back-pressure");

endmodule
`default_nettype wire

[hw/rtl/jqd_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// jqd_queue
// One class FIFO: job slots in flops, head, tail and fill count.
// ----------------------------------------------------------------------------
module jqd_queue
    import jqd_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire q_ctl_t  ctl,
    input  wire job_t    wr_job,
    output job_t         head_job,
    output q_stat_t      stat
);

    job_t              slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0] head_reg, head_next;
    logic [QPTR_W-1:0] tail_reg, tail_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctl.push) begin
            tail_next  = ptr_inc(tail_reg);
            count_next = count_reg + 1'b1;
        end else if (ctl.pop) begin
            head_next  = ptr_inc(head_reg);
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.push) begin
            slots[tail_reg] <= wr_job;
        end
    end

    assign head_job   = slots[head_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));

    a_push_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.push |-> !stat.full)
        else $error("push into full queue");

    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.pop |-> !stat.empty)
        else $error("pop from empty queue");

    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !ctl.push && !ctl.pop |=> $stable(count_reg))
        else $error("fill count moved without push or pop");

endmodule
`default_nettype wire

[verif/multi_class_job_queue_dispatcher_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_class_job_queue_dispatcher_top_tb
// Self-checking bench for the job queue dispatcher. A short directed table
// covers the class codes, empty and refused asks, and the node factor limits.
// Random phases follow, each with its own node factors, add/ask mix and
// back-pressure. An in-bench queue model predicts the results the table does not fix.
// ----------------------------------------------------------------------------
module multi_class_job_queue_dispatcher_top_tb;
    import jqd_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int DIR_ROWS       = 23;
    localparam int NUM_PHASES     = 7;
    localparam int PHASE_REQUESTS = 147;
    localparam int DRAIN_CYCLES   = 8;

    localparam logic [CLASS_W-1:0] CLS_RSVD_6 = 3'd6;
    localparam logic [CLASS_W-1:0] CLS_RSVD_7 = 3'd7;

    typedef struct packed {
        logic               action;
        logic [CLASS_W-1:0] job_class;
        logic [ID_W-1:0]    job_id;
        logic [TIME_W-1:0]  run_time;
        logic [CPU_W-1:0]   cpu_need;
        logic [GPU_W-1:0]   gpu_need;
        logic [NODES_W-1:0] available_nodes;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CLASS_W-1:0]  cls;
        logic [ID_W-1:0]     id;
        logic [TIME_W-1:0]   run_time;
        logic [CPU_W-1:0]    cpu_need;
        logic [GPU_W-1:0]    gpu_need;
    } result_t;

    typedef struct packed {
        request_t req;
        logic     fixed;
        result_t  res;
    } row_t;

    typedef struct packed {
        logic [FACTOR_W-1:0] cpu_f;
        logic [FACTOR_W-1:0] gpu_f;
        logic [7:0]          add_pct;
        logic [7:0]          idle;
        logic                pick_random;
    } phase_t;

    localparam result_t NO_CHECK  = '0;
    localparam result_t RES_ADDED = '{status: ST_ADDED, default: '0};
    localparam result_t RES_NONE  = '{status: ST_NONE, default: '0};
    localparam result_t RES_BAD   = '{status: ST_BAD, default: '0};

    logic                 aclk              = 1'b0;
    logic                 aresetn           = 1'b0;
    logic                 cfg_valid         = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index         = '0;
    logic [FACTOR_W-1:0]  cfg_data          = '0;
    logic                 s_valid           = 1'b0;
    logic                 s_ready;
    logic                 s_action          = 1'b0;
    logic [CLASS_W-1:0]   s_job_class       = '0;
    logic [ID_W-1:0]      s_job_id          = '0;
    logic [TIME_W-1:0]    s_run_time        = '0;
    logic [CPU_W-1:0]     s_cpu_need        = '0;
    logic [GPU_W-1:0]     s_gpu_need        = '0;
    logic [NODES_W-1:0]   s_available_nodes = '0;
    logic                 m_valid;
    logic                 m_ready           = 1'b0;
    logic [STATUS_W-1:0]  m_status;
    logic [CLASS_W-1:0]   m_granted_class;
    logic [ID_W-1:0]      m_granted_id;
    logic [TIME_W-1:0]    m_granted_time;
    logic [CPU_W-1:0]     m_granted_cpu_need;
    logic [GPU_W-1:0]     m_granted_gpu_need;

    int      idle_pct    = 27;
    int      errors      = 0;
    int      cycle_count = 0;
    result_t pending_results [$];

    job_t                queued_jobs [NUM_QUEUES][QUEUE_DEPTH];
    int                  queue_head  [NUM_QUEUES] = '{default: 0};
    int                  queue_tail  [NUM_QUEUES] = '{default: 0};
    int                  queue_fill  [NUM_QUEUES] = '{default: 0};
    logic [FACTOR_W-1:0] cpu_factor = CPU_FACTOR_RESET;
    logic [FACTOR_W-1:0] gpu_factor = GPU_FACTOR_RESET;

    row_t directed_rows [DIR_ROWS] = '{
        '{'{ACT_ASK, CLS_SHORT,  16'h0000, 24'h000000, 16'h0000, 12'h000, 12'd0},
            1'b1, RES_NONE},
        '{'{ACT_ASK, CLS_MULTI,  16'h0000, 24'h000000, 16'h0000, 12'h000, 12'd4095},
            1'b1, RES_NONE},
        '{'{ACT_ASK, CLS_RSVD_6, 16'h0000, 24'h000000, 16'h0000, 12'h000, 12'd0},
            1'b1, RES_BAD},
        '{'{ACT_ASK, CLS_RSVD_7, 16'hffff, 24'hffffff, 16'hffff, 12'hfff, 12'd4095},
            1'b1, RES_BAD},
        '{'{ACT_ADD, CLS_MULTI,  16'h1111, 24'h000001, 16'h0001, 12'h001, 12'd0},
            1'b1, RES_BAD},
        '{'{ACT_ADD, CLS_RSVD_6, 16'h2222, 24'h000002, 16'h0002, 12'h002, 12'd0},
            1'b1, RES_BAD},
        '{'{ACT_ADD, CLS_RSVD_7, 16'hffff, 24'hffffff, 16'hffff, 12'hfff, 12'd4095},
            1'b1, RES_BAD},
        '{'{ACT_ASK, CLS_LARGE,  16'h0000, 24'h000000, 16'h0000, 12'h000, 12'd4095},
            1'b1, RES_NONE},
        '{'{ACT_ASK, CLS_HUGE,   16'h0000, 24'h000000, 16'h0000, 12'h000, 12'd4095},
            1'b1, RES_NONE},
        '{'{ACT_ADD, CLS_SHORT,  16'hffff, 24'hffffff, 16'hffff, 12'hfff, 12'd4095},
            1'b1, RES_ADDED},
        '{'{ACT_ADD, CLS_MEDIUM, 16'h0000, 24'h000000, 16'h0000, 12'h000, 12'd0},
            1'b1, RES_ADDED},
        '{'{ACT_ADD, CLS_LARGE,  16'h1234, 24'hffffff, 16'h0100, 12'h000, 12'd0},
            1'b1, RES_ADDED},
        '{'{ACT_ADD, CLS_HUGE,   16'h5555, 24'haaaaaa, 16'haaaa, 12'haaa, 12'd0},
            1'b1, RES_ADDED},
        '{'{ACT_ADD, CLS_GPU,    16'habcd, 24'h000005, 16'h0000, 12'hfff, 12'd0},
            1'b1, RES_ADDED},
        '{'{ACT_ASK, CLS_GPU,    16'h0000, 24'h000000, 16'h0000, 12'h000, 12'd2047},
            1'b1, RES_NONE},
        '{'{ACT_ASK, CLS_GPU,    16'h0000, 24'h000000, 16'h0000, 12'h000, 12'd2048},
            1'b1, '{ST_GRANTED, CLS_GPU, 16'habcd, 24'h000005, 16'h0000, 12'hfff}},
        '{'{ACT_ASK, CLS_GPU,    16'h0000, 24'h000000, 16'h0000, 12'h000, 12'd4095},
            1'b1, RES_NONE},
        '{'{ACT_ASK, CLS_SHORT,  16'h0000, 24'h000000, 16'h0000, 12'h000, 12'd4095},
            1'b1, RES_NONE},
        '{'{ACT_ASK, CLS_LARGE,  16'h0000, 24'h000000, 16'h0000, 12'h000, 12'd4095},
            1'b1, RES_NONE},
        '{'{ACT_ASK, CLS_HUGE,   16'h0000, 24'h000000, 16'h0000, 12'h000, 12'd4095},
            1'b1, RES_NONE},
        '{'{ACT_ASK, CLS_MULTI,  16'h0000, 24'h000000, 16'h0000, 12'h000, 12'd4095},
            1'b0, NO_CHECK},
        '{'{ACT_ASK, CLS_MEDIUM, 16'h0000, 24'h000000, 16'h0000, 12'h000, 12'd0},
            1'b0, NO_CHECK},
        '{'{ACT_ASK, CLS_MULTI,  16'h0000, 24'h000000, 16'h0000, 12'h000, 12'd0},
            1'b0, NO_CHECK}
    };

    // cpu, gpu, add %, idle %, random factors
    phase_t phase_plan [NUM_PHASES] = '{
        '{8'd255, 8'd255, 8'd60, 8'd27, 1'b0},
        '{8'd1,   8'd1,   8'd75, 8'd27, 1'b0},
        '{8'd255, 8'd255, 8'd30, 8'd0,  1'b0},
        '{8'd0,   8'd0,   8'd50, 8'd27, 1'b0},
        '{8'd0,   8'd0,   8'd55, 8'd27, 1'b1},
        '{8'd0,   8'd0,   8'd45, 8'd27, 1'b1},
        '{8'd16,  8'd2,   8'd50, 8'd27, 1'b0}
    };

    multi_class_job_queue_dispatcher_top DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_action           (s_action),
        .s_job_class        (s_job_class),
        .s_job_id           (s_job_id),
        .s_run_time         (s_run_time),
        .s_cpu_need         (s_cpu_need),
        .s_gpu_need         (s_gpu_need),
        .s_available_nodes  (s_available_nodes),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_granted_class    (m_granted_class),
        .m_granted_id       (m_granted_id),
        .m_granted_time     (m_granted_time),
        .m_granted_cpu_need (m_granted_cpu_need),
        .m_granted_gpu_need (m_granted_gpu_need)
    );

    always #5 aclk = ~aclk;

    function automatic result_t predict_dispatch(input request_t r);
        result_t res;
        job_t    head_job;
        int      q;
        int      sel;
        logic    covered;
        res     = '0;
        sel     = -1;
        covered = 1'b0;
        q       = int'(r.job_class);
        if (r.action == ACT_ADD) begin
            if (r.job_class > CLS_GPU) begin
                res.status = ST_BAD;
            end else if (queue_fill[q] >= QUEUE_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                queued_jobs[q][queue_tail[q]] = '{r.job_id, r.run_time, r.cpu_need, r.gpu_need};
                queue_tail[q] = (queue_tail[q] + 1) % QUEUE_DEPTH;
                queue_fill[q]++;
                res.status = ST_ADDED;
            end
            return res;
        end
        if (r.job_class > CLS_MULTI) begin
            res.status = ST_BAD;
            return res;
        end
        case (r.job_class)
            CLS_LARGE, CLS_HUGE: ;
            CLS_GPU: begin
                if (queue_fill[q] != 0) begin
                    sel     = q;
                    covered = int'(r.available_nodes) * int'(gpu_factor)
                              >= int'(queued_jobs[q][queue_head[q]].gpu_need);
                end
            end
            CLS_MULTI: begin
                // longest head run time wins, lower class on a tie
                for (int c = 0; c < 3; c++) begin
                    if (queue_fill[c] != 0 && (sel < 0 ||
                        queued_jobs[c][queue_head[c]].run_time >
                        queued_jobs[sel][queue_head[sel]].run_time)) begin
                        sel = c;
                    end
                end
            end
            default: begin
                if (queue_fill[q] != 0) begin
                    sel = q;
                end
            end
        endcase
        if (sel >= 0 && r.job_class != CLS_GPU) begin
            covered = int'(r.available_nodes) * int'(cpu_factor)
                      >= int'(queued_jobs[sel][queue_head[sel]].cpu_need);
        end
        if (sel >= 0 && covered) begin
            head_job = queued_jobs[sel][queue_head[sel]];
            res = '{ST_GRANTED, CLASS_W'(sel), head_job.id, head_job.run_time,
                    head_job.cpu_need, head_job.gpu_need};
            queue_head[sel] = (queue_head[sel] + 1) % QUEUE_DEPTH;
            queue_fill[sel]--;
        end else begin
            res.status = ST_NONE;
        end
        return res;
    endfunction

    function automatic request_t random_request(input int add_pct);
        request_t r;
        r.action = ($urandom_range(99) < add_pct) ? ACT_ADD : ACT_ASK;
        if ($urandom_range(99) < 5) begin
            r.job_class = $urandom_range(1) ? CLS_RSVD_7 : CLS_RSVD_6;
        end else begin
            r.job_class = CLASS_W'($urandom_range(CLS_MULTI));
        end
        r.job_id = ID_W'($urandom);
        // frequent equal run times exercise the multi tie-break
        case ($urandom_range(3))
            0:       r.run_time = '0;
            1:       r.run_time = '1;
            2:       r.run_time = TIME_W'($urandom_range(3));
            default: r.run_time = TIME_W'($urandom);
        endcase
        r.cpu_need = ($urandom_range(7) == 0) ? CPU_W'($urandom_range(15)) : CPU_W'($urandom);
        r.gpu_need = ($urandom_range(7) == 0) ? GPU_W'($urandom_range(15)) : GPU_W'($urandom);
        case ($urandom_range(5))
            0:       r.available_nodes = '0;
            1:       r.available_nodes = '1;
            default: r.available_nodes = NODES_W'($urandom);
        endcase
        return r;
    endfunction

    task automatic idle_gap();
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic send_request(input request_t r);
        s_valid           <= 1'b1;
        s_action          <= r.action;
        s_job_class       <= r.job_class;
        s_job_id          <= r.job_id;
        s_run_time        <= r.run_time;
        s_cpu_need        <= r.cpu_need;
        s_gpu_need        <= r.gpu_need;
        s_available_nodes <= r.available_nodes;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic program_factors(input logic [FACTOR_W-1:0] cpu_f,
                                   input logic [FACTOR_W-1:0] gpu_f);
        cfg_valid <= 1'b1;
        cfg_index <= REG_CPU_FACTOR;
        cfg_data  <= cpu_f;
        do @(posedge aclk); while (!cfg_ready);
        cpu_factor = cpu_f;
        cfg_index <= REG_GPU_FACTOR;
        cfg_data  <= gpu_f;
        do @(posedge aclk); while (!cfg_ready);
        gpu_factor = gpu_f;
        cfg_valid <= 1'b0;
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d", m_status);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_status);
                    errors++;
                end
                if (m_granted_class !== want.cls) begin
                    $error("granted_class: expected %0d, actual %0d", want.cls, m_granted_class);
                    errors++;
                end
                if (m_granted_id !== want.id) begin
                    $error("granted_id: expected %0h, actual %0h", want.id, m_granted_id);
                    errors++;
                end
                if (m_granted_time !== want.run_time) begin
                    $error("granted_time: expected %0h, actual %0h",
                           want.run_time, m_granted_time);
                    errors++;
                end
                if (m_granted_cpu_need !== want.cpu_need) begin
                    $error("granted_cpu_need: expected %0h, actual %0h",
                           want.cpu_need, m_granted_cpu_need);
                    errors++;
                end
                if (m_granted_gpu_need !== want.gpu_need) begin
                    $error("granted_gpu_need: expected %0h, actual %0h",
                           want.gpu_need, m_granted_gpu_need);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("multi_class_job_queue_dispatcher_top regression: fail");
            $finish;
        end
    end

    initial begin
        request_t            req;
        result_t             res;
        logic [FACTOR_W-1:0] cf;
        logic [FACTOR_W-1:0] gf;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (int n = 0; n < DIR_ROWS; n++) begin
            idle_gap();
            send_request(directed_rows[n].req);
            res = predict_dispatch(directed_rows[n].req);
            pending_results.insert(pending_results.size(),
                                   directed_rows[n].fixed ? directed_rows[n].res : res);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            cf = phase_plan[p].cpu_f;
            gf = phase_plan[p].gpu_f;
            if (phase_plan[p].pick_random) begin
                cf = FACTOR_W'($urandom_range(255, 1));
                gf = FACTOR_W'($urandom_range(255, 1));
            end
            program_factors(cf, gf);
            idle_pct <= phase_plan[p].idle;
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                req = random_request(phase_plan[p].add_pct);
                idle_gap();
                send_request(req);
                pending_results.insert(pending_results.size(), predict_dispatch(req));
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("multi_class_job_queue_dispatcher_top regression: pass");
        end else begin
            $display("multi_class_job_queue_dispatcher_top regression: fail");
        end
        $finish;
    end

endmodule
